/* hdl/apf_pkg.sv */
// Package: shared types, constants and word-coding functions of the packet formatter.
`default_nettype none
package apf_pkg;

  // Packet length alignment (1..16) and the width of the length counter.
  localparam int PAD_ALIGN = 12;
  localparam int MOD_W     = (PAD_ALIGN > 1) ? $clog2(PAD_ALIGN) : 1;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 10;
  localparam int SUM_W   = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DID  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SDID = 1'b1;

  // Fixed words.
  localparam logic [WORD_W-1:0] WORD_ADF0 = 10'h000;
  localparam logic [WORD_W-1:0] WORD_ADF1 = 10'h3FF;
  localparam logic [WORD_W-1:0] WORD_PAD  = 10'h040;

  // Header word positions after the first flag word.
  localparam logic [2:0] HDR_FLAG1 = 3'd1;
  localparam logic [2:0] HDR_FLAG2 = 3'd2;
  localparam logic [2:0] HDR_DID   = 3'd3;
  localparam logic [2:0] HDR_SDID  = 3'd4;
  localparam logic [2:0] HDR_COUNT = 3'd5;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_kind_t;

  // One classified item: a start or an in-packet data byte.
  typedef struct packed {
    op_kind_t          kind;
    logic [BYTE_W-1:0] value;
    logic              finish;  // last byte of the packet (or zero-count start)
  } op_t;

  // Even parity in bit 8, its inverse in bit 9.
  function automatic logic [WORD_W-1:0] with_parity(input logic [BYTE_W-1:0] b);
    logic p;
    p = ^b;
    return {~p, p, b};
  endfunction

  function automatic logic [WORD_W-1:0] checksum_word(input logic [SUM_W-1:0] s);
    return {~s[SUM_W-1], s};
  endfunction

  function automatic logic [MOD_W-1:0] mod_inc(input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] r;
    if (m == MOD_W'(PAD_ALIGN - 1)) r = '0;
    else r = m + MOD_W'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/apf_in_if.sv */
// Interface: input byte channel (command and value).
`default_nettype none
interface apf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [apf_pkg::BYTE_W-1:0]   value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

/* hdl/apf_out_if.sv */
// Interface: output word channel (ten-bit word and end-of-packet mark).
`default_nettype none
interface apf_out_if;
  logic                         valid;
  logic                         ready;
  logic [apf_pkg::WORD_W-1:0]   word;
  logic                         end_of_packet;

  modport source (output valid, output word, output end_of_packet, input ready);
  modport sink   (input valid, input word, input end_of_packet, output ready);
endinterface
`default_nettype wire

/* hdl/apf_front.sv */
// Front end: accept items, track packet state and classify items into operations.
`default_nettype none
module apf_front (
  input  wire logic     clk,
  input  wire logic     rst,
  apf_in_if.sink        bytes,
  input  wire logic     queue_full,
  output apf_pkg::op_t  push_op,
  output logic          push
);

  logic                         packet_open;
  logic [apf_pkg::BYTE_W-1:0]   bytes_left;
  logic                         accept;

  assign bytes.ready = !queue_full;
  assign accept      = bytes.valid && bytes.ready;

  always_comb begin
    push_op.value = bytes.value;
    if (bytes.command == apf_pkg::CMD_START) begin
      push_op.kind   = apf_pkg::OP_START;
      push_op.finish = (bytes.value == '0);
      push           = accept;
    end else begin
      push_op.kind   = apf_pkg::OP_DATA;
      push_op.finish = (bytes_left == apf_pkg::BYTE_W'(1));
      // drop data bytes outside a packet
      push           = accept && packet_open;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      bytes_left  <= '0;
    end else if (push) begin
      if (push_op.kind == apf_pkg::OP_START) begin
        packet_open <= !push_op.finish;
        bytes_left  <= bytes.value;
      end else begin
        packet_open <= !push_op.finish;
        bytes_left  <= bytes_left - apf_pkg::BYTE_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/apf_queue.sv */
// Short queue of classified operations between front and back.
`default_nettype none
module apf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire apf_pkg::op_t  push_op,
  input  wire logic          pop,
  output apf_pkg::op_t       head_op,
  output logic               not_empty,
  output logic               full
);

  apf_pkg::op_t                 mem [apf_pkg::QUEUE_DEPTH];
  logic [apf_pkg::QPTR_W-1:0]   wr_ptr;
  logic [apf_pkg::QPTR_W-1:0]   rd_ptr;
  logic [apf_pkg::QCNT_W-1:0]   count;
  logic                         do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == apf_pkg::QCNT_W'(apf_pkg::QUEUE_DEPTH));
  assign head_op   = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + apf_pkg::QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + apf_pkg::QPTR_W'(1);
      if (push && !do_pop)      count <= count + apf_pkg::QCNT_W'(1);
      else if (!push && do_pop) count <= count - apf_pkg::QCNT_W'(1);
    end
  end

endmodule
`default_nettype wire

/* hdl/apf_back.sv */
// Back end: expand operations into header, data, checksum and padding words.
`default_nettype none
module apf_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [apf_pkg::BYTE_W-1:0]  did_value,
  input  wire logic [apf_pkg::BYTE_W-1:0]  sdid_value,
  input  wire apf_pkg::op_t                head_op,
  input  wire logic                        not_empty,
  output logic                             pop,
  apf_out_if.source                        words
);

  typedef enum logic [3:0] {
    ST_FETCH = 4'b0001,
    ST_HDR   = 4'b0010,
    ST_CSUM  = 4'b0100,
    ST_PAD   = 4'b1000
  } state_t;

  state_t                        state, state_next;
  logic [2:0]                    hdr_idx, hdr_idx_next;
  logic [apf_pkg::BYTE_W-1:0]    cur_count, cur_count_next;
  logic                          cur_finish, cur_finish_next;
  logic [apf_pkg::SUM_W-1:0]     sum, sum_next;
  logic [apf_pkg::MOD_W-1:0]     mod, mod_next;
  logic                          out_valid, out_valid_next;
  logic [apf_pkg::WORD_W-1:0]    out_word, out_word_next;
  logic                          out_eop, out_eop_next;
  logic                          adv;
  logic [apf_pkg::WORD_W-1:0]    data_word;
  logic [apf_pkg::WORD_W-1:0]    hdr_word;

  assign words.valid         = out_valid;
  assign words.word          = out_word;
  assign words.end_of_packet = out_eop;

  // advance when the output register is empty or being taken
  assign adv       = !out_valid || words.ready;
  assign data_word = apf_pkg::with_parity(head_op.value);

  always_comb begin
    unique case (hdr_idx)
      apf_pkg::HDR_DID:   hdr_word = apf_pkg::with_parity(did_value);
      apf_pkg::HDR_SDID:  hdr_word = apf_pkg::with_parity(sdid_value);
      apf_pkg::HDR_COUNT: hdr_word = apf_pkg::with_parity(cur_count);
      default:            hdr_word = apf_pkg::WORD_ADF1;
    endcase
  end

  always_comb begin
    state_next      = state;
    hdr_idx_next    = hdr_idx;
    cur_count_next  = cur_count;
    cur_finish_next = cur_finish;
    sum_next        = sum;
    mod_next        = mod;
    out_valid_next  = out_valid && !words.ready;
    out_word_next   = out_word;
    out_eop_next    = out_eop;
    pop             = 1'b0;
    if (adv) begin
      unique case (state)
        ST_FETCH: begin
          if (not_empty) begin
            pop            = 1'b1;
            out_valid_next = 1'b1;
            out_eop_next   = 1'b0;
            if (head_op.kind == apf_pkg::OP_START) begin
              out_word_next   = apf_pkg::WORD_ADF0;
              sum_next        = '0;
              mod_next        = apf_pkg::mod_inc('0);
              hdr_idx_next    = apf_pkg::HDR_FLAG1;
              cur_count_next  = head_op.value;
              cur_finish_next = head_op.finish;
              state_next      = ST_HDR;
            end else begin
              out_word_next = data_word;
              sum_next      = sum + data_word[apf_pkg::SUM_W-1:0];
              mod_next      = apf_pkg::mod_inc(mod);
              if (head_op.finish) state_next = ST_CSUM;
            end
          end
        end
        ST_HDR: begin
          out_valid_next = 1'b1;
          out_eop_next   = 1'b0;
          out_word_next  = hdr_word;
          mod_next       = apf_pkg::mod_inc(mod);
          hdr_idx_next   = hdr_idx + 3'd1;
          if (hdr_idx != apf_pkg::HDR_FLAG1 && hdr_idx != apf_pkg::HDR_FLAG2) begin
            sum_next = sum + hdr_word[apf_pkg::SUM_W-1:0];
          end
          if (hdr_idx == apf_pkg::HDR_COUNT) begin
            state_next = cur_finish ? ST_CSUM : ST_FETCH;
          end
        end
        ST_CSUM: begin
          out_valid_next = 1'b1;
          out_word_next  = apf_pkg::checksum_word(sum);
          mod_next       = apf_pkg::mod_inc(mod);
          out_eop_next   = (apf_pkg::mod_inc(mod) == '0);
          state_next     = (apf_pkg::mod_inc(mod) == '0) ? ST_FETCH : ST_PAD;
        end
        ST_PAD: begin
          out_valid_next = 1'b1;
          out_word_next  = apf_pkg::WORD_PAD;
          mod_next       = apf_pkg::mod_inc(mod);
          out_eop_next   = (apf_pkg::mod_inc(mod) == '0);
          if (apf_pkg::mod_inc(mod) == '0) state_next = ST_FETCH;
        end
        default: state_next = ST_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FETCH;
      hdr_idx    <= apf_pkg::HDR_FLAG1;
      cur_finish <= 1'b0;
      sum        <= '0;
      mod        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      hdr_idx    <= hdr_idx_next;
      cur_finish <= cur_finish_next;
      sum        <= sum_next;
      mod        <= mod_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_count <= cur_count_next;
    out_word  <= out_word_next;
    out_eop   <= out_eop_next;
  end

endmodule
`default_nettype wire

/* hdl/ancillary_packet_formatter_core.sv */
// Top level: ancillary packet formatter with config registers, front, queue and back.
// With the back end idle, an accepted item is written into the operation queue and its first
//   word is then registered on the output, where the sink can take it.
// Rate: one payload byte per cycle (one word each) while the sink is ready; a start item
//   expands into six header words, a finishing item adds one checksum word and up to
//   PAD_ALIGN-1 padding words, one per cycle, buffered by the four-entry operation queue.
// Reset (rst, synchronous): clears DID/SDID, packet state, queue and output register.
`default_nettype none
module ancillary_packet_formatter_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [apf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [apf_pkg::CFG_DATA_W-1:0]    cfg_data,
  apf_in_if.sink                                 bytes,
  apf_out_if.source                              words
);

  // Header identifiers; the user must write them only while the block is idle (not enforced).
  logic [apf_pkg::BYTE_W-1:0] did_value;
  logic [apf_pkg::BYTE_W-1:0] sdid_value;

  // Front to queue, queue to back.
  apf_pkg::op_t push_op;
  logic         push;
  apf_pkg::op_t head_op;
  logic         not_empty;
  logic         queue_full;
  logic         pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      did_value  <= '0;
      sdid_value <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apf_pkg::REG_DID:  did_value  <= cfg_data;
        apf_pkg::REG_SDID: sdid_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: accept items, drop stray payload bytes, mark the last byte of each packet.
  apf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .queue_full (queue_full),
    .push_op    (push_op),
    .push       (push)
  );

  // Queue: lets header and padding bursts in the back end overlap new input.
  apf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .head_op   (head_op),
    .not_empty (not_empty),
    .full      (queue_full)
  );

  // Back: sequence header, data, checksum and padding into the output register.
  apf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .did_value  (did_value),
    .sdid_value (sdid_value),
    .head_op    (head_op),
    .not_empty  (not_empty),
    .pop        (pop),
    .words      (words)
  );

endmodule
`default_nettype wire

/* dv/anc_packet_checker.sv */
// Checker: predicts the ancillary words of each accepted item and compares the word stream.
module anc_packet_checker
  import apf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  apf_in_if                     bytes_mon,
  apf_out_if                    words_mon,
  output int                    mismatch_count,
  output int                    words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              eop;
  } anc_word_t;

  anc_word_t expected_words[$];

  // Shadow registers and packet state of the formatter.
  logic [BYTE_W-1:0] did_reg;
  logic [BYTE_W-1:0] sdid_reg;
  logic              pkt_open;
  logic [BYTE_W-1:0] bytes_left;
  logic [SUM_W-1:0]  pkt_sum;
  int                len_mod;

  initial begin
    mismatch_count = 0;
    words_pending  = 0;
  end

  // Even parity of the byte in bit 8, its complement in bit 9.
  function automatic logic [WORD_W-1:0] coded_byte(input logic [BYTE_W-1:0] b);
    logic odd;
    odd = 1'b0;
    for (int i = 0; i < BYTE_W; i++) odd = odd ^ b[i];
    return odd ? {2'b01, b} : {2'b10, b};
  endfunction

  function automatic void emit(input logic [WORD_W-1:0] w);
    anc_word_t e;
    e.word = w;
    e.eop  = 1'b0;
    expected_words.insert(expected_words.size(), e);
    len_mod = (len_mod + 1) % PAD_ALIGN;
  endfunction

  function automatic void emit_summed(input logic [WORD_W-1:0] w);
    pkt_sum = pkt_sum + w[SUM_W-1:0];
    emit(w);
  endfunction

  // Checksum, padding up to the alignment, end mark on the last word.
  function automatic void close_packet();
    emit({~pkt_sum[SUM_W-1], pkt_sum});
    while (len_mod != 0) emit(WORD_PAD);
    expected_words[expected_words.size()-1].eop = 1'b1;
    pkt_open   = 1'b0;
    bytes_left = '0;
  endfunction

  function automatic void format_item(input logic cmd, input logic [BYTE_W-1:0] val);
    if (cmd == CMD_START) begin
      len_mod = 0;
      pkt_sum = '0;
      emit(WORD_ADF0);
      emit(WORD_ADF1);
      emit(WORD_ADF1);
      emit_summed(coded_byte(did_reg));
      emit_summed(coded_byte(sdid_reg));
      emit_summed(coded_byte(val));
      pkt_open   = 1'b1;
      bytes_left = val;
      if (val == '0) close_packet();
    end else if (pkt_open) begin
      emit_summed(coded_byte(val));
      bytes_left = bytes_left - BYTE_W'(1);
      if (bytes_left == '0) close_packet();
    end
  endfunction

  function automatic void check_word(input logic [WORD_W-1:0] w, input logic eop);
    anc_word_t e;
    if (expected_words.size() == 0) begin
      $error("unexpected item: word %h end_of_packet %b", w, eop);
      mismatch_count++;
    end else begin
      e = expected_words.pop_front();
      if (w !== e.word) begin
        $error("word mismatch: expected %h actual %h", e.word, w);
        mismatch_count++;
      end
      if (eop !== e.eop) begin
        $error("end_of_packet mismatch: expected %b actual %b", e.eop, eop);
        mismatch_count++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      did_reg    = '0;
      sdid_reg   = '0;
      pkt_open   = 1'b0;
      bytes_left = '0;
      pkt_sum    = '0;
      len_mod    = 0;
    end else begin
      // Retire output first: an item accepted at this edge cannot have a word out yet.
      if (words_mon.valid && words_mon.ready)
        check_word(words_mon.word, words_mon.end_of_packet);
      if (cfg_we) begin
        if (cfg_index == REG_DID) did_reg = cfg_data;
        else if (cfg_index == REG_SDID) sdid_reg = cfg_data;
      end
      if (bytes_mon.valid && bytes_mon.ready)
        format_item(bytes_mon.command, bytes_mon.value);
    end
    words_pending <= expected_words.size();
  end

endmodule

/* dv/tb_top.sv */
// Testbench top: clock, reset, register writes, byte stimulus, word back-pressure and verdict.
module tb_top;
  import apf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 2000;  // cycles without any accepted item
  localparam int SETTLE_WAIT = 16;    // settle margin after the last expected word
  localparam int PHASE_ITEMS = 97;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int words_pending;
  int idle_cycles;
  int stall_left;
  int sink_draw;
  bit src_gaps;
  bit sink_gaps;

  apf_in_if  bytes_ch();
  apf_out_if words_ch();

  ancillary_packet_formatter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bytes     (bytes_ch),
    .words     (words_ch)
  );

  anc_packet_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .bytes_mon      (bytes_ch),
    .words_mon      (words_ch),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Word sink: after each accepted item, with sink gaps on, draw a random stall and hold ready low for it.
  always @(posedge clk) begin
    if (rst) begin
      words_ch.ready <= 1'b0;
      stall_left     <= 1;
    end else if (words_ch.ready) begin
      if (words_ch.valid) begin
        sink_draw = sink_gaps ? $urandom_range(0, 3) : 0;
        if (sink_draw != 0) begin
          words_ch.ready <= 1'b0;
          stall_left     <= sink_draw;
        end
      end
    end else if (stall_left <= 1) begin
      words_ch.ready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Watchdog: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (bytes_ch.valid && bytes_ch.ready) || (words_ch.valid && words_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Present one item, after a random gap when source gaps are on, and hold it until the block takes it.
  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] val);
    int gap;
    gap = src_gaps ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      bytes_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bytes_ch.valid   <= 1'b1;
    bytes_ch.command <= cmd;
    bytes_ch.value   <= val;
    do @(posedge clk); while (!bytes_ch.ready);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline settle.
  task automatic drain();
    bytes_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Write both identifiers on back-to-back cycles, holding the enable high across them.
  task automatic write_ids(input logic [CFG_DATA_W-1:0] did, input logic [CFG_DATA_W-1:0] sdid);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DID;
    cfg_data  <= did;
    @(posedge clk);
    cfg_index <= REG_SDID;
    cfg_data  <= sdid;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed packets with random size and bytes; some abandoned, some stray bytes.
  task automatic run_random_phase(input int quota);
    int sent;
    int sel;
    int count;
    int cut;
    bit dangling;
    sent     = 0;
    dangling = 1'b0;
    while (sent < quota) begin
      sel = $urandom_range(0, 99);
      if (sel < 8 && !dangling) begin
        // Stray byte with no open packet: ignored, not counted.
        send_item(CMD_DATA, BYTE_W'($urandom));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 1) count = $urandom_range(100, 255);
        else if (sel < 25) count = $urandom_range(7, 30);
        else count = $urandom_range(0, 6);
        cut = count;
        if (count > 0 && $urandom_range(0, 9) == 0) cut = $urandom_range(0, count - 1);
        // Stop the payload at the phase quota; a long packet is then left open.
        if (cut > quota - sent - 1) cut = quota - sent - 1;
        send_item(CMD_START, BYTE_W'(count));
        sent++;
        for (int i = 0; i < cut; i++) begin
          send_item(CMD_DATA, BYTE_W'($urandom));
          sent++;
        end
        // An abandoned packet stays open until the next start.
        dangling = (cut != count);
      end
    end
    // Close any open packet so the phase ends idle.
    if (dangling) begin
      send_item(CMD_START, '0);
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_DID;
    cfg_data         = '0;
    bytes_ch.valid   = 1'b0;
    bytes_ch.command = CMD_START;
    bytes_ch.value   = '0;
    src_gaps         = 1'b1;
    sink_gaps        = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identifier extremes, parity of both kinds, checksum wrap.
    write_ids(8'hFF, 8'h00);
    send_item(CMD_DATA, 8'h55);    // no open packet: dropped
    send_item(CMD_START, 8'h00);   // zero count: header, checksum and padding at once
    send_item(CMD_START, 8'h01);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_START, 8'h03);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h80);
    send_item(CMD_DATA, 8'h01);
    send_item(CMD_START, 8'hFF);   // largest count, abandoned after two bytes
    send_item(CMD_DATA, 8'h7F);
    send_item(CMD_DATA, 8'hAA);
    send_item(CMD_START, 8'h02);   // new start drops the open packet
    send_item(CMD_DATA, 8'h01);
    send_item(CMD_DATA, 8'hFE);
    drain();

    write_ids(8'h00, 8'hFF);
    send_item(CMD_START, 8'h05);   // exactly one alignment block: checksum carries the end mark
    send_item(CMD_DATA, 8'h12);
    send_item(CMD_DATA, 8'h34);
    send_item(CMD_DATA, 8'h56);
    send_item(CMD_DATA, 8'h78);
    send_item(CMD_DATA, 8'h9A);
    send_item(CMD_START, 8'h00);
    drain();

    // Random phases: vary identifiers and idling, one phase with no gaps at all.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_ids(8'hFF, 8'hFF);
        1: write_ids(8'h00, 8'h00);
        default: write_ids(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      endcase
      src_gaps  = (p != 1);
      sink_gaps = (p != 1) && (p != 3);
      run_random_phase(PHASE_ITEMS);
      drain();
    end

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
